// File: hw/rtl/qma_pkg.sv
// Shared types, codes and helpers for the QR mask apply block.
`timescale 1ns / 1ps

package qma_pkg;

    // Smallest legal symbol side (version 1)
    localparam logic [7:0] MIN_SYMBOL_SIZE = 8'd21;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_SIZE  = 2'd1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Standard mask pattern codes
    typedef enum logic [2:0] {
        MASK_CHECKER     = 3'd0,  // (i+j)%2
        MASK_ROWS        = 3'd1,  // i%2
        MASK_COLS3       = 3'd2,  // j%3
        MASK_DIAG3       = 3'd3,  // (i+j)%3
        MASK_BLOCKS      = 3'd4,  // (i/2 + j/3)%2
        MASK_PROD_SUM    = 3'd5,  // (ij)%2 + (ij)%3
        MASK_PROD_PARITY = 3'd6,  // ((ij)%2 + (ij)%3)%2
        MASK_MIXED       = 3'd7   // ((i+j)%2 + (ij)%3)%2
    } mask_sel_t;

    // Position of one module, reduced to what the masks need
    typedef struct packed {
        logic       bit_in;     // module value
        logic       last;       // final module of the symbol
        logic       row_odd;    // i[0]
        logic       row_bit1;   // i[1], parity of i/2
        logic       col_odd;    // j[0]
        logic [1:0] row_mod3;   // i%3
        logic [1:0] col_mod3;   // j%3
        logic       col_div3;   // parity of j/3
    } qma_item_t;

    // Residue step mod 3
    function automatic logic [1:0] inc_mod3(input logic [1:0] a);
        logic [1:0] r;
        r = (a == 2'd2) ? 2'd0 : a + 2'd1;
        return r;
    endfunction

    // (a+b)%3 for residues
    function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    // (a*b)%3 for residues
    function automatic logic [1:0] mul_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] r;
        if (a == 2'd0 || b == 2'd0) begin
            r = 2'd0;
        end else if (a == b) begin
            r = 2'd1;       // 1*1 and 2*2
        end else begin
            r = 2'd2;       // 1*2
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/qma_front.sv
// Front end: position counters and classification of each accepted module.
`timescale 1ns / 1ps

module qma_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                module_in,
    input  logic [7:0]          size_m1,
    output qma_pkg::qma_item_t  item
);

    logic [7:0] row_reg, row_next;
    logic [7:0] col_reg, col_next;
    logic [1:0] row_mod3_reg, row_mod3_next;
    logic [1:0] col_mod3_reg, col_mod3_next;
    logic       col_div3_reg, col_div3_next;
    logic       row_end;
    logic       last;

    // Row end and symbol end
    assign row_end = (col_reg >= size_m1);
    assign last    = row_end && (row_reg >= size_m1);

    // Item handed to the queue
    always_comb
    begin
        item.bit_in   = module_in;
        item.last     = last;
        item.row_odd  = row_reg[0];
        item.row_bit1 = row_reg[1];
        item.col_odd  = col_reg[0];
        item.row_mod3 = row_mod3_reg;
        item.col_mod3 = col_mod3_reg;
        item.col_div3 = col_div3_reg;
    end

    // Counter advance, residues kept alongside
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        row_mod3_next = row_mod3_reg;
        col_mod3_next = col_mod3_reg;
        col_div3_next = col_div3_reg;
        if (accept)
        begin
            if (last)
            begin
                row_next      = 8'd0;
                row_mod3_next = 2'd0;
                col_next      = 8'd0;
                col_mod3_next = 2'd0;
                col_div3_next = 1'b0;
            end
            else if (row_end)
            begin
                row_next      = row_reg + 8'd1;
                row_mod3_next = qma_pkg::inc_mod3(row_mod3_reg);
                col_next      = 8'd0;
                col_mod3_next = 2'd0;
                col_div3_next = 1'b0;
            end
            else
            begin
                col_next      = col_reg + 8'd1;
                col_mod3_next = qma_pkg::inc_mod3(col_mod3_reg);
                col_div3_next = col_div3_reg ^ (col_mod3_reg == 2'd2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= 8'd0;
            col_reg      <= 8'd0;
            row_mod3_reg <= 2'd0;
            col_mod3_reg <= 2'd0;
            col_div3_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            row_mod3_reg <= row_mod3_next;
            col_mod3_reg <= col_mod3_next;
            col_div3_reg <= col_div3_next;
        end
    end

endmodule

// File: hw/rtl/qma_queue.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module qma_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  qma_pkg::qma_item_t  wr_item,
    output logic                full,
    input  logic                rd_en,
    output qma_pkg::qma_item_t  rd_item,
    output logic                not_empty
);

    localparam logic [qma_pkg::QCNT_W-1:0] DEPTH_CNT = qma_pkg::QCNT_W'(qma_pkg::QUEUE_DEPTH);
    localparam logic [qma_pkg::QPTR_W-1:0] LAST_PTR  =
        qma_pkg::QPTR_W'(qma_pkg::QUEUE_DEPTH - 1);

    qma_pkg::qma_item_t               slot_reg [qma_pkg::QUEUE_DEPTH];
    logic [qma_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [qma_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [qma_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_wr;
    logic                             do_rd;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign rd_item   = slot_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: hw/rtl/qma_back.sv
// Back end: mask bit evaluation, XOR and result output register.
`timescale 1ns / 1ps

module qma_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  qma_pkg::qma_item_t  q_item,
    output logic                q_take,
    input  qma_pkg::mask_sel_t  mask_pattern,
    output logic                module_out,
    output logic                last_module,
    output logic                empty,
    input  logic                pop
);

    logic       out_valid_reg, out_valid_next;
    logic       bit_reg;
    logic       last_reg;
    logic       hit;
    logic       prod_odd;
    logic [1:0] prod_mod3;
    logic [1:0] sum_mod3;

    assign prod_odd  = q_item.row_odd & q_item.col_odd;
    assign prod_mod3 = qma_pkg::mul_mod3(q_item.row_mod3, q_item.col_mod3);
    assign sum_mod3  = qma_pkg::add_mod3(q_item.row_mod3, q_item.col_mod3);

    // Mask bit for the selected pattern
    always_comb
    begin
        case (mask_pattern)
            qma_pkg::MASK_CHECKER:     hit = !(q_item.row_odd ^ q_item.col_odd);
            qma_pkg::MASK_ROWS:        hit = !q_item.row_odd;
            qma_pkg::MASK_COLS3:       hit = (q_item.col_mod3 == 2'd0);
            qma_pkg::MASK_DIAG3:       hit = (sum_mod3 == 2'd0);
            qma_pkg::MASK_BLOCKS:      hit = !(q_item.row_bit1 ^ q_item.col_div3);
            qma_pkg::MASK_PROD_SUM:    hit = !prod_odd && (prod_mod3 == 2'd0);
            qma_pkg::MASK_PROD_PARITY: hit = !(prod_odd ^ prod_mod3[0]);
            qma_pkg::MASK_MIXED:       hit = !((q_item.row_odd ^ q_item.col_odd) ^ prod_mod3[0]);
            default:                   hit = 1'b0;
        endcase
    end

    // Take a beat when the output register is free or being drained
    assign q_take = q_valid && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            bit_reg  <= q_item.bit_in ^ hit;
            last_reg <= q_item.last;
        end
    end

    assign module_out  = bit_reg;
    assign last_module = last_reg;
    assign empty       = !out_valid_reg;

endmodule

// File: hw/rtl/qr_mask_apply_top.sv
// Top level of the QR data mask apply block.
//
// channel  | handshake                     | payload
// ---------+-------------------------------+---------------------------------
// input    | push / full                   | module_in
// result   | empty / pop                   | module_out, last_module
// config   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One module per cycle sustained while pop drains the result; a pushed module
// is written into the two-entry queue, then into the result register. The front
// counters, the queue and the result register each pass one beat a cycle.
// Reset clears the position counters, the queue and the result valid flag and
// loads mask pattern 0 and size 21; no clearing pass follows.
// A stalled result fills the queue, then full rises; cfg_ready is always high.
`timescale 1ns / 1ps

module qr_mask_apply_top
#(
    parameter int MAX_SYMBOL_SIZE = 177
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             module_in,
    output logic                             empty,
    input  logic                             pop,
    output logic                             module_out,
    output logic                             last_module,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qma_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);

    localparam logic [7:0] MAX_SIZE = 8'(MAX_SYMBOL_SIZE);

    qma_pkg::mask_sel_t  mask_pattern_reg, mask_pattern_next;
    logic [7:0]          symbol_size_reg, symbol_size_next;
    logic [7:0]          size_eff;
    logic [7:0]          size_m1;
    logic                accept;
    qma_pkg::qma_item_t  front_item;
    qma_pkg::qma_item_t  q_item;
    logic                q_valid;
    logic                q_take;
    logic                cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Configuration registers, unknown indexes ignored
    always_comb
    begin
        mask_pattern_next = mask_pattern_reg;
        symbol_size_next  = symbol_size_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                qma_pkg::CFG_MASK_PATTERN: mask_pattern_next = qma_pkg::mask_sel_t'(cfg_data[2:0]);
                qma_pkg::CFG_SYMBOL_SIZE:  symbol_size_next  = cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_pattern_reg <= qma_pkg::MASK_CHECKER;
            symbol_size_reg  <= qma_pkg::MIN_SYMBOL_SIZE;
        end
        else
        begin
            mask_pattern_reg <= mask_pattern_next;
            symbol_size_reg  <= symbol_size_next;
        end
    end

    // Size in use, clamped to the legal range
    always_comb
    begin
        if (symbol_size_reg < qma_pkg::MIN_SYMBOL_SIZE)
        begin
            size_eff = qma_pkg::MIN_SYMBOL_SIZE;
        end
        else if (symbol_size_reg > MAX_SIZE)
        begin
            size_eff = MAX_SIZE;
        end
        else
        begin
            size_eff = symbol_size_reg;
        end
    end

    assign size_m1 = size_eff - 8'd1;
    assign accept  = push && !full;

    qma_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .module_in (module_in),
        .size_m1   (size_m1),
        .item      (front_item)
    );

    qma_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_item   (front_item),
        .full      (full),
        .rd_en     (q_take),
        .rd_item   (q_item),
        .not_empty (q_valid)
    );

    qma_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_take       (q_take),
        .mask_pattern (mask_pattern_reg),
        .module_out   (module_out),
        .last_module  (last_module),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
